[sv/mdsp_pkg.sv]
// ----------------------------------------------------------------------------
// Multibyte delimiter splitter package
// Shared widths, register indexes, result kinds and the control and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package mdsp_pkg;

   localparam int MAX_DELIMITER_DEF = 8;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 4;
   localparam int DELIM_W = 64;
   localparam int IDX_W   = 1;
   localparam int USER_W  = 3;

   localparam logic [LEN_W-1:0]   LEN_RESET   = 4'd1;
   localparam logic [DELIM_W-1:0] DELIM_RESET = 64'd44;

   // Configuration register indexes
   localparam logic [IDX_W-1:0] REG_DELIM_LENGTH = 1'b0;
   localparam logic [IDX_W-1:0] REG_DELIM_BYTES  = 1'b1;

   // Kind of result loaded into the output register
   localparam logic [1:0] EMIT_NONE = 2'd0;
   localparam logic [1:0] EMIT_BYTE = 2'd1;
   localparam logic [1:0] EMIT_END  = 2'd2;

   typedef struct packed {
      logic       accept;     // take the input byte into the window
      logic       pop;        // drop the oldest window byte
      logic [1:0] emit;       // result to load into the output register
      logic       string_end;
      logic       run_last;
   } mdsp_cmd_type;

   typedef struct packed {
      logic slot_free;  // output register empty or being taken
      logic full;       // the incoming byte completes the window
      logic match;      // completed window equals the delimiter
      logic len_one;    // active delimiter length is one
      logic fill_one;   // exactly one byte held in the window
   } mdsp_status_type;

endpackage

[sv/mdsp_datapath.sv]
// ----------------------------------------------------------------------------
// Multibyte delimiter splitter datapath
// Delimiter registers, byte window with fill count, delimiter comparison and
// the registered result stage.
// ----------------------------------------------------------------------------
module mdsp_datapath
   import mdsp_pkg::*;
#(
   parameter int MAX_DELIMITER = MAX_DELIMITER_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [DELIM_W-1:0]  csr_wdata,
   input  logic [BYTE_W-1:0]   char_in,
   input  mdsp_cmd_type        cmd,
   output mdsp_status_type     status,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [BYTE_W-1:0]   rsp_tdata,
   output logic [USER_W-1:0]   rsp_tuser,
   output logic                rsp_tlast
);

   localparam int FILL_W = $clog2(MAX_DELIMITER + 1);
   localparam int WIN_W  = MAX_DELIMITER * BYTE_W;

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [WIN_W-1:0]  delim_ff, delim_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic [USER_W-1:0] out_user_ff, out_user_in;
   logic              out_last_ff, out_last_in;

   logic [FILL_W-1:0] len_act;
   logic [WIN_W-1:0]  win_app;
   logic              mismatch;

   // Out-of-range lengths are clamped into one to MAX_DELIMITER.
   always_comb begin
      if (len_ff == '0) begin
         len_act = FILL_W'(1);
      end else if (len_ff > LEN_W'(MAX_DELIMITER)) begin
         len_act = FILL_W'(MAX_DELIMITER);
      end else begin
         len_act = FILL_W'(len_ff);
      end
   end

   // Window with the incoming byte placed at the fill position.
   always_comb begin
      win_app  = win_ff;
      mismatch = 1'b0;
      for (int i = 0; i < MAX_DELIMITER; i++) begin
         if (fill_ff == FILL_W'(i)) begin
            win_app[i*BYTE_W +: BYTE_W] = char_in;
         end
      end
      for (int i = 0; i < MAX_DELIMITER; i++) begin
         if ((FILL_W'(i) < len_act) &&
             (win_app[i*BYTE_W +: BYTE_W] != delim_ff[i*BYTE_W +: BYTE_W])) begin
            mismatch = 1'b1;
         end
      end
   end

   assign status.slot_free = !out_valid_ff || rsp_tready;
   assign status.full      = (fill_ff + FILL_W'(1)) == len_act;
   assign status.match     = !mismatch;
   assign status.len_one   = len_act == FILL_W'(1);
   assign status.fill_one  = fill_ff == FILL_W'(1);

   always_comb begin
      len_in   = len_ff;
      delim_in = delim_ff;
      win_in   = win_ff;
      fill_in  = fill_ff;

      if (cmd.accept) begin
         if (status.full && status.match) begin
            fill_in = '0;
         end else if (status.full) begin
            // Oldest byte leaves; the fill count stays at one below the length.
            win_in = win_app >> BYTE_W;
         end else begin
            win_in  = win_app;
            fill_in = fill_ff + FILL_W'(1);
         end
      end else if (cmd.pop) begin
         win_in  = win_ff >> BYTE_W;
         fill_in = fill_ff - FILL_W'(1);
      end

      if (csr_we) begin
         case (csr_index)
            REG_DELIM_LENGTH: begin
               len_in  = csr_wdata[LEN_W-1:0];
               fill_in = '0;
            end
            REG_DELIM_BYTES: begin
               delim_in = csr_wdata[WIN_W-1:0];
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      case (cmd.emit)
         EMIT_BYTE: begin
            out_valid_in = 1'b1;
            out_byte_in  = win_app[BYTE_W-1:0];
            out_user_in  = {1'b0, 1'b0, 1'b1};
            out_last_in  = cmd.run_last;
         end
         EMIT_END: begin
            out_valid_in = 1'b1;
            out_byte_in  = '0;
            out_user_in  = {cmd.string_end, 1'b1, 1'b0};
            out_last_in  = cmd.run_last;
         end
         default: begin
            out_byte_in = out_byte_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_RESET;
         delim_ff     <= DELIM_RESET[WIN_W-1:0];
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         delim_ff     <= delim_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      out_byte_ff <= out_byte_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[sv/mdsp_controller.sv]
// ----------------------------------------------------------------------------
// Multibyte delimiter splitter controller
// Accepts bytes, then after the final byte sequences the window flush and
// the closing part end.
// ----------------------------------------------------------------------------
module mdsp_controller
   import mdsp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  logic            req_tlast,
   input  mdsp_status_type status,
   output logic            req_tready,
   output mdsp_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FLUSH = 2'd1;
   localparam logic [1:0] ST_END   = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE) && status.slot_free;

   always_comb begin
      state_in       = state_ff;
      cmd.accept     = 1'b0;
      cmd.pop        = 1'b0;
      cmd.emit       = EMIT_NONE;
      cmd.string_end = 1'b0;
      cmd.run_last   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && status.slot_free) begin
               cmd.accept = 1'b1;
               if (status.full && status.match) begin
                  cmd.emit       = EMIT_END;
                  cmd.string_end = req_tlast;
                  cmd.run_last   = 1'b1;
               end else if (status.full) begin
                  cmd.emit     = EMIT_BYTE;
                  cmd.run_last = !req_tlast;
                  if (req_tlast) begin
                     // A one-byte window is already empty after this byte.
                     state_in = status.len_one ? ST_END : ST_FLUSH;
                  end
               end else if (req_tlast) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (status.slot_free) begin
               cmd.pop  = 1'b1;
               cmd.emit = EMIT_BYTE;
               if (status.fill_one) begin
                  state_in = ST_END;
               end
            end
         end
         ST_END: begin
            if (status.slot_free) begin
               cmd.emit       = EMIT_END;
               cmd.string_end = 1'b1;
               cmd.run_last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/multibyte_delimiter_splitter.sv]
// ----------------------------------------------------------------------------
// Multibyte delimiter splitter
// Splits a byte stream into parts at a configurable delimiter of up to
// MAX_DELIMITER bytes.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle as long as the single output register is
// free, and an ordinary byte produces at most one result, so a string streams
// through at one byte a cycle. The final byte of a string (tlast), unless it
// completes the delimiter, starts a flush that drains the window one byte a
// cycle while the output register is free and then emits the closing part
// end; no byte is accepted during the flush. Writing the delimiter length
// empties the window. There is no clearing pass after reset.
module multibyte_delimiter_splitter
   import mdsp_pkg::*;
#(
   parameter int MAX_DELIMITER = MAX_DELIMITER_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [DELIM_W-1:0] csr_wdata,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [BYTE_W-1:0]  req_tdata,   // [7:0] char_in
   input  logic               req_tlast,   // final_char
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [BYTE_W-1:0]  rsp_tdata,   // [7:0] part_byte
   output logic [USER_W-1:0]  rsp_tuser,   // [0] byte_valid, [1] part_end, [2] string_end
   output logic               rsp_tlast    // run_last
);

   mdsp_cmd_type    cmd;
   mdsp_status_type status;

   mdsp_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   mdsp_datapath #(
      .MAX_DELIMITER (MAX_DELIMITER)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .char_in    (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A result is only loaded when the output register can take it.
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit != EMIT_NONE) |-> status.slot_free)
      else $error("result loaded over a pending result");

   // An item is accepted only when it can be answered at once.
   a_accept_slot_free: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!rsp_tvalid || rsp_tready))
      else $error("item accepted while output register blocked");

   // The string end always closes a part and the run of its item.
   a_string_end_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> (rsp_tuser[1] && rsp_tlast && !rsp_tuser[0]))
      else $error("string end without part end and run end");

   // Flushing and popping never happen together with taking a new byte.
   a_accept_pop_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !req_tready)
      else $error("window pop while accepting items");

endmodule

[verif/tb_multibyte_delimiter_splitter.sv]
// ----------------------------------------------------------------------------
// Multibyte delimiter splitter testbench
// Streams strings one byte per item into the splitter and holds its own model
// of the byte window. That model predicts every data byte and part end. Random
// gaps and stalls are applied on both streams. The delimiter length and bytes
// are rewritten between strings and part way through strings.
// ----------------------------------------------------------------------------
module tb_multibyte_delimiter_splitter;
   import mdsp_pkg::*;

   localparam int SETTLE_CYCLES = MAX_DELIMITER_DEF + 4;
   localparam int QUIET_LIMIT   = 1000;
   localparam int RANDOM_ITEMS  = 450;

   // Bit positions in rsp_tuser
   localparam int USER_BYTE_VALID = 0;
   localparam int USER_PART_END   = 1;
   localparam int USER_STRING_END = 2;

   typedef struct packed {
      logic [BYTE_W-1:0] part_byte;
      logic              byte_valid;
      logic              part_end;
      logic              string_end;
      logic              run_last;
   } part_result_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               csr_we     = 1'b0;
   logic [IDX_W-1:0]   csr_index  = '0;
   logic [DELIM_W-1:0] csr_wdata  = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [BYTE_W-1:0]  req_tdata  = '0;   // [7:0] char_in
   logic               req_tlast  = 1'b0; // final_char
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [BYTE_W-1:0]  rsp_tdata;         // [7:0] part_byte
   logic [USER_W-1:0]  rsp_tuser;         // [0] byte_valid, [1] part_end, [2] string_end
   logic               rsp_tlast;         // run_last

   // Model of the splitter state and its registers
   logic [LEN_W-1:0]   model_length;
   logic [DELIM_W-1:0] model_delim;
   logic [BYTE_W-1:0]  model_window [MAX_DELIMITER_DEF];
   int unsigned        model_fill;

   part_result_type    expected_parts [$];
   int unsigned        mismatches  = 0;
   int unsigned        items_sent  = 0;
   int unsigned        quiet_count = 0;
   int unsigned        stall_left  = 0;
   bit                 idle_on     = 1'b1;

   multibyte_delimiter_splitter u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned active_length(logic [LEN_W-1:0] n);
      if (n == 0) return 1;
      if (n > MAX_DELIMITER_DEF) return MAX_DELIMITER_DEF;
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] delim_byte(int unsigned pos);
      return model_delim[8*pos +: 8];
   endfunction

   function automatic part_result_type make_part(logic [BYTE_W-1:0] b, logic valid,
                                                 logic pend, logic send);
      part_result_type r;
      r.part_byte  = b;
      r.byte_valid = valid;
      r.part_end   = pend;
      r.string_end = send;
      r.run_last   = 1'b0;
      return r;
   endfunction

   // The oldest window byte leaves as part data.
   function automatic void release_oldest();
      expected_parts.push_back(make_part(model_window[0], 1'b1, 1'b0, 1'b0));
      for (int i = 1; i < MAX_DELIMITER_DEF; i++) model_window[i-1] = model_window[i];
      model_fill--;
   endfunction

   function automatic void predict_split(logic [BYTE_W-1:0] c, logic fin);
      int unsigned     len;
      int unsigned     first;
      bit              hit;
      bit              matched;
      part_result_type r;
      len     = active_length(model_length);
      first   = expected_parts.size();
      matched = 1'b0;
      if (model_fill >= len) model_fill = 0;
      model_window[model_fill] = c;
      model_fill++;
      if (model_fill == len) begin
         hit = 1'b1;
         for (int i = 0; i < len; i++)
            if (model_window[i] != delim_byte(i)) hit = 1'b0;
         if (hit) begin
            model_fill = 0;
            matched    = 1'b1;
            expected_parts.push_back(make_part('0, 1'b0, 1'b1, fin));
         end else begin
            release_oldest();
         end
      end
      // A delimiter closing the string already carried string_end.
      if (fin && !matched) begin
         while (model_fill > 0) release_oldest();
         expected_parts.push_back(make_part('0, 1'b0, 1'b1, 1'b1));
      end
      if (expected_parts.size() > first) begin
         r = expected_parts.pop_back();
         r.run_last = 1'b1;
         expected_parts.push_back(r);
      end
   endfunction

   task automatic send_item(input logic [BYTE_W-1:0] c, input logic fin);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_split(c, fin);
      items_sent++;
   endtask

   // Brings the block to rest: every expected item received and the window
   // logic given time to finish.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_parts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DELIM_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_DELIM_LENGTH) begin
         model_length = value[LEN_W-1:0];
         model_fill   = 0;
      end else begin
         model_delim = value;
      end
      // A gap with csr_we low so that a following write starts on a later edge.
      @(posedge clock);
   endtask

   task automatic test_default_comma();
      idle_on = 1'b0;
      send_item(8'h00, 1'b0);
      send_item(8'h2C, 1'b0);
      send_item(8'hFF, 1'b1);
      // A string made of the delimiter alone is one empty part.
      send_item(8'h2C, 1'b1);
      send_item(8'h7F, 1'b0);
      send_item(8'h2C, 1'b1);
      settle();
   endtask

   task automatic test_length_limits();
      idle_on = 1'b1;
      // Length zero acts as one; the upper delimiter bytes must be ignored.
      write_reg(REG_DELIM_BYTES, 64'hFFFF_FFFF_FFFF_FF80);
      write_reg(REG_DELIM_LENGTH, 64'd0);
      send_item(8'h80, 1'b0);
      send_item(8'h01, 1'b1);
      settle();
      // Length fifteen acts as the full eight bytes.
      write_reg(REG_DELIM_BYTES, 64'h0123_4567_89AB_CDEF);
      write_reg(REG_DELIM_LENGTH, 64'd15);
      for (int i = 0; i < MAX_DELIMITER_DEF; i++)
         send_item(delim_byte(i), i == MAX_DELIMITER_DEF - 1);
      send_item(8'h55, 1'b1);
      settle();
   endtask

   task automatic test_midstring_writes();
      write_reg(REG_DELIM_LENGTH, 64'd2);
      write_reg(REG_DELIM_BYTES, 64'hA5A5_A5A5_A5A5_3A3B);
      send_item(8'h3B, 1'b0);
      settle();
      // The held byte stays; the second comparison uses the new byte.
      write_reg(REG_DELIM_BYTES, 64'hF0E1_D2C3_B4A5_773B);
      send_item(8'h77, 1'b1);
      send_item(8'h10, 1'b0);
      settle();
      // A length write drops the held byte without output.
      write_reg(REG_DELIM_LENGTH, 64'd3);
      send_item(8'h3B, 1'b0);
      send_item(8'h77, 1'b0);
      send_item(8'hA5, 1'b1);
      settle();
   endtask

   task automatic random_config();
      int unsigned pick;
      logic [LEN_W-1:0] len;
      pick = $urandom_range(0, 9);
      if (pick == 0) len = '0;
      else if (pick == 1) len = LEN_W'($urandom_range(MAX_DELIMITER_DEF + 1, 15));
      else len = LEN_W'($urandom_range(1, MAX_DELIMITER_DEF));
      write_reg(REG_DELIM_BYTES, {$urandom, $urandom});
      write_reg(REG_DELIM_LENGTH, len);
   endtask

   task automatic test_random_strings();
      logic [BYTE_W-1:0] text [$];
      int unsigned target;
      int unsigned len;
      int unsigned pick;
      int unsigned split_at;
      bit          noise;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            settle();
            random_config();
         end
         idle_on = ($urandom_range(0, 3) != 0);
         len     = active_length(model_length);
         noise   = ($urandom_range(0, 9) == 0);
         target  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
         text.delete();
         while (text.size() < target) begin
            pick = noise ? 7 : $urandom_range(0, 7);
            if (pick <= 1) begin
               for (int i = 0; i < len; i++) text.push_back(delim_byte(i));
            end else if (pick == 2 && len > 1) begin
               // A broken delimiter: a prefix followed by any byte.
               for (int i = 0; i < $urandom_range(1, len - 1); i++)
                  text.push_back(delim_byte(i));
               text.push_back(BYTE_W'($urandom_range(0, 255)));
            end else if (pick <= 4) begin
               text.push_back(delim_byte($urandom_range(0, len - 1)));
            end else begin
               text.push_back(BYTE_W'($urandom_range(0, 255)));
            end
         end
         split_at = text.size();
         if (text.size() > 1 && $urandom_range(0, 11) == 0)
            split_at = $urandom_range(1, text.size() - 1);
         for (int i = 0; i < text.size(); i++) begin
            if (i == split_at) begin
               settle();
               if ($urandom_range(0, 1) == 0)
                  write_reg(REG_DELIM_BYTES, {$urandom, $urandom});
               else
                  write_reg(REG_DELIM_LENGTH, $urandom_range(0, 15));
            end
            send_item(text[i], i == text.size() - 1);
         end
      end
   endtask

   // Result side: random stalls, and each item checked against the oldest
   // expectation.
   always @(posedge clock) begin : check_results
      part_result_type seen;
      part_result_type want;
      int unsigned     n;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         seen.part_byte  = rsp_tdata;
         seen.byte_valid = rsp_tuser[USER_BYTE_VALID];
         seen.part_end   = rsp_tuser[USER_PART_END];
         seen.string_end = rsp_tuser[USER_STRING_END];
         seen.run_last   = rsp_tlast;
         if (expected_parts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: byte %h valid %b end %b str_end %b last %b",
                        seen.part_byte, seen.byte_valid, seen.part_end,
                        seen.string_end, seen.run_last);
         end else begin
            want = expected_parts.pop_front();
            if (seen.part_byte !== want.part_byte || seen.byte_valid !== want.byte_valid ||
                seen.part_end !== want.part_end || seen.string_end !== want.string_end ||
                seen.run_last !== want.run_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected byte %h valid %b end %b str_end %b last %b, %s",
                           want.part_byte, want.byte_valid, want.part_end,
                           want.string_end, want.run_last,
                           $sformatf("got byte %h valid %b end %b str_end %b last %b",
                                     seen.part_byte, seen.byte_valid, seen.part_end,
                                     seen.string_end, seen.run_last));
            end
         end
         n = idle_on ? $urandom_range(0, 3) : 0;
         stall_left <= n;
         rsp_tready <= (n == 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_count <= 0;
         end else begin
            quiet_count <= quiet_count + 1;
            if (quiet_count + 1 >= QUIET_LIMIT) begin
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

   initial begin
      model_length = LEN_RESET;
      model_delim  = DELIM_RESET;
      model_fill   = 0;
      for (int i = 0; i < MAX_DELIMITER_DEF; i++) model_window[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_comma();
      test_length_limits();
      test_midstring_writes();
      test_random_strings();
      settle();
      if (mismatches == 0 && expected_parts.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[sim.f]
sv/mdsp_pkg.sv
sv/mdsp_datapath.sv
sv/mdsp_controller.sv
sv/multibyte_delimiter_splitter.sv
verif/tb_multibyte_delimiter_splitter.sv
